// File: rtl/ttms_pkg.sv
// Shared types and constants for the tilt triggered motor sequencer.
package ttms_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIGGER_ANGLE  = 3'd0,
		REG_START_TIME     = 3'd1,
		REG_BRUSH_TIME     = 3'd2,
		REG_STOP_DELAY     = 3'd3,
		REG_OC_HOLD        = 3'd4,
		REG_CURRENT_LIMIT  = 3'd5,
		REG_CURRENT_OFFSET = 3'd6
	} cfg_reg_t;

	// register reset values
	localparam logic [23:0] START_TIME_RST = 24'd1500000;
	localparam logic [23:0] STOP_DELAY_RST = 24'd3000000;
	localparam logic [23:0] OC_HOLD_RST    = 24'd15000000;

	// current sensing
	localparam int          ADC_MID   = 512;
	localparam int          SQ_W      = 22;
	localparam int          SUMSQ_W   = 24;
	localparam int          CNT_W     = 6;

	// angle handling
	localparam logic [7:0]  TILT_MAX  = 8'd180;
	localparam int          WSUM_W    = 14;

	localparam int          TIME_W    = 24;
	localparam int          STARTS_W  = 32;
	localparam int          BRUSH_W   = 40;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_BRUSH = 3'd2,
		PH_OC    = 3'd3,
		PH_STOP  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0]  elapsed_ms;
		logic [7:0]  tilt_degrees;
		logic [9:0]  current_adc;
		logic        start_request;
		logic        clear_counters;
	} in_item_t;

	typedef struct packed {
		logic [2:0]          phase;
		logic                motor_enable;
		logic                motor_direction;
		logic [WSUM_W-1:0]   angle_window_sum;
		logic                overcurrent;
		logic [TIME_W-1:0]   phase_time_ms;
		logic [STARTS_W-1:0] start_count;
		logic [BRUSH_W-1:0]  brushing_total_ms;
	} out_item_t;

	// sequencer state as seen by the top level
	typedef struct packed {
		phase_t              phase;
		logic                motor_on;
		logic                direction;
		logic [TIME_W-1:0]   timer;
		logic [STARTS_W-1:0] starts;
		logic [BRUSH_W-1:0]  brush_total;
	} seq_state_t;

	// sequencer timing configuration
	typedef struct packed {
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] brush_time;
		logic [TIME_W-1:0] stop_delay;
		logic [TIME_W-1:0] oc_hold;
	} seq_cfg_t;

endpackage

// File: rtl/tilt_triggered_motor_sequencer_core.sv
// Top level of the tilt triggered motor sequencer.
//
// One input transaction per tick carries elapsed milliseconds, tilt angle,
// a raw current sample, a start request and a counter clear. Each tick
// produces exactly one output transaction with the phase, motor drive,
// window angle sum, overcurrent flag, phase time and the two counters.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. Configuration is a write-only port (cfg_write, cfg_index,
// cfg_data); the user must write it while no tick is in flight; the block
// does not enforce this. Input goes through an input stage that squares
// the current sample, then the update stage that loads the output register.
// Throughput is one tick per cycle; the output register stalls both stages
// together, so in_stall follows out_stall while a result waits.
// Reset clears the window, current block, sequencer (idle, direction one)
// and counters and loads the register defaults; the angle memory needs no
// clearing pass, its entries read as zero until the window wraps once.
module tilt_triggered_motor_sequencer_core #(
	parameter int ANGLE_WINDOW = 70,
	parameter int RMS_SAMPLES  = 50
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [ttms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ttms_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ttms_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ttms_pkg::out_item_t                 out_data
);
	import ttms_pkg::*;

	localparam int SLOT_W = (ANGLE_WINDOW > 1) ? $clog2(ANGLE_WINDOW) : 1;
	localparam int SUM_W  = $clog2(180 * ANGLE_WINDOW + 1);

	// configuration registers
	logic [7:0]         trigger_q;
	seq_cfg_t           seq_cfg_q;
	logic [SUMSQ_W-1:0] limit_q;
	logic signed [9:0]  offset_q;

	// pipeline
	logic               advance;
	logic               process;
	logic               valid_s1;
	in_item_t           item_s1;
	logic [SQ_W-1:0]    sq_s1;
	logic signed [11:0] centered;
	logic signed [23:0] prod;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [SUM_W-1:0]   angle_sum;
	logic               tilted;
	logic               over_nx;
	phase_t             phase;
	seq_state_t         seq_nx;
	logic               sample_en;

	assign advance   = !(out_valid_q && out_stall);
	assign in_stall  = !advance;
	assign process   = valid_s1 && advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q            <= '0;
			seq_cfg_q.start_time <= START_TIME_RST;
			seq_cfg_q.brush_time <= '0;
			seq_cfg_q.stop_delay <= STOP_DELAY_RST;
			seq_cfg_q.oc_hold    <= OC_HOLD_RST;
			limit_q              <= '0;
			offset_q             <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TRIGGER_ANGLE:  trigger_q            <= cfg_data[7:0];
				REG_START_TIME:     seq_cfg_q.start_time <= cfg_data;
				REG_BRUSH_TIME:     seq_cfg_q.brush_time <= cfg_data;
				REG_STOP_DELAY:     seq_cfg_q.stop_delay <= cfg_data;
				REG_OC_HOLD:        seq_cfg_q.oc_hold    <= cfg_data;
				REG_CURRENT_LIMIT:  limit_q              <= cfg_data;
				REG_CURRENT_OFFSET: offset_q             <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// input stage: center, offset and square the current sample
	always_comb begin
		centered = $signed({2'b00, in_data.current_adc}) - 12'sd512
			+ 12'(offset_q);
		prod     = centered * centered;
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1 <= in_data;
			sq_s1   <= prod[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			out_valid_q <= valid_s1;
		end
	end

	// update stage
	assign sample_en = process && (phase == PH_IDLE || phase == PH_BRUSH);

	ttms_angle_window #(
		.WINDOW (ANGLE_WINDOW),
		.SUM_W  (SUM_W),
		.SLOT_W (SLOT_W)
	) u_angle (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (process),
		.tilt    (item_s1.tilt_degrees),
		.trigger (trigger_q),
		.sum_nx  (angle_sum),
		.tilted  (tilted)
	);

	ttms_current_monitor #(
		.RMS_SAMPLES (RMS_SAMPLES)
	) u_current (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (sample_en),
		.sq      (sq_s1),
		.limit   (limit_q),
		.over_nx (over_nx)
	);

	ttms_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (process),
		.elapsed   (item_s1.elapsed_ms),
		.tilted    (tilted),
		.start_req (item_s1.start_request),
		.clear     (item_s1.clear_counters),
		.over      (over_nx),
		.cfg       (seq_cfg_q),
		.phase     (phase),
		.state_nx  (seq_nx)
	);

	// result register
	always_ff @(posedge clk) begin
		if (process) begin
			out_q.phase             <= 3'(seq_nx.phase);
			out_q.motor_enable      <= seq_nx.motor_on;
			out_q.motor_direction   <= seq_nx.direction;
			out_q.angle_window_sum  <= (32'(angle_sum) > 32'h3FFF) ? '1
				: WSUM_W'(angle_sum);
			out_q.overcurrent       <= over_nx;
			out_q.phase_time_ms     <= seq_nx.timer;
			out_q.start_count       <= seq_nx.starts;
			out_q.brushing_total_ms <= seq_nx.brush_total;
		end
	end

endmodule

// File: rtl/ttms_angle_window.sv
// Moving window sum of tilt angles with a prefetched window memory.
module ttms_angle_window #(
	parameter int WINDOW = 70,
	parameter int SUM_W  = 14,
	parameter int SLOT_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [7:0]       tilt,
	input  logic [7:0]       trigger,
	output logic [SUM_W-1:0] sum_nx,
	output logic             tilted
);
	import ttms_pkg::*;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

	logic [7:0]        mem [WINDOW];
	logic [7:0]        rd_q;
	logic [7:0]        last_q;
	logic              byp_q;
	logic              wrapped_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_nx;
	logic [SLOT_W-1:0] rd_addr;
	logic [SUM_W-1:0]  sum_q;
	logic [7:0]        tilt_c;
	logic [7:0]        old_val;
	logic [15:0]       thresh;

	// clamp the angle and find the slot after this one
	always_comb begin
		tilt_c  = (tilt > TILT_MAX) ? TILT_MAX : tilt;
		slot_nx = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
		rd_addr = en ? slot_nx : slot_q;
	end

	// entry leaving the window: zero until the window has been filled once
	always_comb begin
		old_val = byp_q ? last_q : rd_q;
		if (!wrapped_q) begin
			old_val = '0;
		end
		sum_nx = sum_q - SUM_W'(old_val) + SUM_W'(tilt_c);
		thresh = 16'(trigger) * 16'(WINDOW);
		tilted = 16'(sum_nx) >= thresh;
	end

	// window memory: write the current slot, prefetch the next
	always_ff @(posedge clk) begin
		if (en) begin
			mem[slot_q] <= tilt_c;
		end
		rd_q   <= mem[rd_addr];
		last_q <= tilt_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			sum_q     <= '0;
			wrapped_q <= 1'b0;
			byp_q     <= 1'b0;
		end else begin
			byp_q <= en && (slot_nx == slot_q);
			if (en) begin
				slot_q <= slot_nx;
				sum_q  <= sum_nx;
				if (slot_nx == '0) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/ttms_current_monitor.sv
// Block sum of squared current samples compared with a limit.
module ttms_current_monitor #(
	parameter int RMS_SAMPLES = 50
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [ttms_pkg::SQ_W-1:0]    sq,
	input  logic [ttms_pkg::SUMSQ_W-1:0] limit,
	output logic                         over_nx
);
	import ttms_pkg::*;

	logic [SUMSQ_W-1:0] sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               flag_q;
	logic [SUMSQ_W:0]   raw;
	logic [SUMSQ_W-1:0] sum_sat;
	logic [CNT_W:0]     cnt_inc;
	logic               block_end;

	// saturating accumulate and block end detect
	always_comb begin
		raw       = {1'b0, sum_q} + (SUMSQ_W + 1)'(sq);
		sum_sat   = raw[SUMSQ_W] ? '1 : raw[SUMSQ_W-1:0];
		cnt_inc   = {1'b0, cnt_q} + 1'b1;
		block_end = cnt_inc >= (CNT_W + 1)'(RMS_SAMPLES);
		over_nx   = (en && block_end) ? (sum_sat > limit) : flag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			flag_q <= 1'b0;
		end else if (en) begin
			flag_q <= over_nx;
			if (block_end) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_sat;
				cnt_q <= cnt_inc[CNT_W-1:0];
			end
		end
	end

endmodule

// File: rtl/ttms_sequencer.sv
// Five phase motor sequencer with phase timer, start and brushing counters.
module ttms_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [7:0]            elapsed,
	input  logic                  tilted,
	input  logic                  start_req,
	input  logic                  clear,
	input  logic                  over,
	input  ttms_pkg::seq_cfg_t    cfg,
	output ttms_pkg::phase_t      phase,
	output ttms_pkg::seq_state_t  state_nx
);
	import ttms_pkg::*;

	seq_state_t      st_q;
	phase_t          phase_nx;
	logic [TIME_W:0] tsum;
	logic [TIME_W-1:0] d;
	logic            due;
	logic [STARTS_W-1:0] starts_base;
	logic [BRUSH_W-1:0]  brush_base;

	assign phase = st_q.phase;

	// advance the timer, saturating
	always_comb begin
		tsum = {1'b0, st_q.timer} + (TIME_W + 1)'(elapsed);
		d    = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
		due  = d > cfg.brush_time;
		starts_base = clear ? '0 : st_q.starts;
		brush_base  = clear ? '0 : st_q.brush_total;
	end

	// next phase
	always_comb begin
		phase_nx = st_q.phase;
		case (st_q.phase)
			PH_IDLE: begin
				if (tilted || start_req) phase_nx = PH_START;
			end
			PH_START: begin
				if (d > cfg.start_time) phase_nx = PH_BRUSH;
			end
			PH_BRUSH: begin
				if (over || (due && !tilted)) phase_nx = over ? PH_OC : PH_STOP;
			end
			PH_OC: begin
				if (d > cfg.oc_hold) phase_nx = PH_IDLE;
			end
			PH_STOP: begin
				if (d > cfg.stop_delay) phase_nx = PH_IDLE;
			end
			default: phase_nx = st_q.phase;
		endcase
	end

	// timer, motor drive and counters
	always_comb begin
		state_nx             = st_q;
		state_nx.phase       = phase_nx;
		state_nx.timer       = d;
		state_nx.starts      = starts_base;
		state_nx.brush_total = brush_base;
		case (st_q.phase)
			PH_IDLE: begin
				if (tilted || start_req) state_nx.timer = '0;
			end
			PH_START: begin
				if (!st_q.motor_on) begin
					state_nx.direction = !st_q.direction;
					state_nx.starts    = starts_base + 1'b1;
					state_nx.timer     = '0;
					state_nx.motor_on  = 1'b1;
				end
			end
			PH_BRUSH: begin
				if (over || due) begin
					state_nx.brush_total = brush_base + BRUSH_W'(d);
					state_nx.timer       = '0;
					if (over || !tilted) state_nx.motor_on = 1'b0;
				end
			end
			default: state_nx.timer = d;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase       <= PH_IDLE;
			st_q.motor_on    <= 1'b0;
			st_q.direction   <= 1'b1;
			st_q.timer       <= '0;
			st_q.starts      <= '0;
			st_q.brush_total <= '0;
		end else if (en) begin
			st_q <= state_nx;
		end
	end

endmodule
